@@ sv/pwl_pkg.sv @@
// Shared types and constants for the password lock controller.
package pwl_pkg;

  localparam int PASS_LEN = 4;
  localparam int CNT_W    = $clog2(PASS_LEN + 1);
  localparam int IDX_W    = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;

  localparam logic [7:0] CH_LOWER_E  = 8'h65;
  localparam logic [7:0] CH_UPPER_E  = 8'h45;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;
  localparam logic [7:0] CH_ZERO     = 8'h30;

  typedef enum logic [1:0] {
    MODE_VERIFY  = 2'd0,
    MODE_UPDATE  = 2'd1,
    MODE_SUCCESS = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_GRANTED = 3'd1,
    EV_DENIED  = 3'd2,
    EV_ALREADY = 3'd3,
    EV_UPDATED = 3'd4,
    EV_EXIT    = 3'd5
  } event_t;

  typedef logic [PASS_LEN-1:0][7:0] pass_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_code;
    logic       button_level;
    logic       restart;
  } poll_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CNT_W-1:0] count;
    pass_t            entry;
    pass_t            stored;
    logic             button_prev;
    logic             led;
    logic             active;
  } lock_state_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_code;
    logic [2:0] entry_event;
    logic       change_prompt;
    logic       led_lit;
    logic [1:0] current_mode;
    logic       block_active;
  } result_t;

endpackage

@@ sv/pwl_ifs.sv @@
// Valid/ready channel interfaces for polls and results.
interface pwl_poll_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] char_code;
  logic       button_level;
  logic       restart;

  modport source (output valid, char_valid, char_code, button_level, restart, input ready);
  modport sink   (input valid, char_valid, char_code, button_level, restart, output ready);
endinterface

interface pwl_result_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [7:0] echo_code;
  logic [2:0] entry_event;
  logic       change_prompt;
  logic       led_lit;
  logic [1:0] current_mode;
  logic       block_active;

  modport source (output valid, echo_valid, echo_code, entry_event, change_prompt, led_lit,
                  current_mode, block_active, input ready);
  modport sink   (input valid, echo_valid, echo_code, entry_event, change_prompt, led_lit,
                  current_mode, block_active, output ready);
endinterface

@@ sv/pwl_step.sv @@
// Next-state and result logic for one poll of the lock.
module pwl_step
  import pwl_pkg::*;
(
  input  poll_t       poll,
  input  lock_state_t cur,
  output lock_state_t nxt,
  output result_t     res
);

  logic do_button;
  logic is_exit;
  logic is_eol;
  logic is_print;
  logic takes_chars;

  assign is_exit  = (poll.char_code == CH_LOWER_E) || (poll.char_code == CH_UPPER_E);
  assign is_eol   = (poll.char_code == CH_CR) || (poll.char_code == CH_LF);
  assign is_print = (poll.char_code >= CH_PRINT_LO) && (poll.char_code <= CH_PRINT_HI);

  always_comb begin
    nxt       = cur;
    res       = '0;
    do_button = 1'b1;

    if (poll.restart) begin
      nxt.active = 1'b1;
      nxt.mode   = MODE_VERIFY;
      nxt.count  = '0;
      nxt.entry  = '0;
      nxt.led    = 1'b0;
    end

    takes_chars = (nxt.mode == MODE_VERIFY) || (nxt.mode == MODE_UPDATE);

    if (!nxt.active) begin
      nxt.button_prev = poll.button_level;
      do_button       = 1'b0;
    end else if (poll.char_valid) begin
      res.echo_valid = 1'b1;
      res.echo_code  = poll.char_code;
      if (is_exit) begin
        res.entry_event = EV_EXIT;
        nxt.active      = 1'b0;
        nxt.led         = 1'b0;
        do_button       = 1'b0;
      end else if (is_eol) begin
        do_button = 1'b0;
        if (nxt.mode == MODE_SUCCESS) begin
          res.entry_event = EV_ALREADY;
          nxt.count       = '0;
          nxt.entry       = '0;
        end else if (nxt.count != '0) begin
          if (nxt.mode == MODE_VERIFY) begin
            if (nxt.entry == nxt.stored) begin
              res.entry_event = EV_GRANTED;
              nxt.led         = 1'b1;
              nxt.mode        = MODE_SUCCESS;
            end else begin
              res.entry_event = EV_DENIED;
            end
          end else if (nxt.mode == MODE_UPDATE) begin
            nxt.stored      = nxt.entry;
            res.entry_event = EV_UPDATED;
            nxt.led         = 1'b0;
            nxt.mode        = MODE_VERIFY;
          end
          nxt.count = '0;
          nxt.entry = '0;
        end
      end else if (takes_chars && is_print && (nxt.count < CNT_W'(PASS_LEN))) begin
        nxt.entry[nxt.count[IDX_W-1:0]] = poll.char_code;
        nxt.count                        = nxt.count + 1'b1;
      end
    end

    if (do_button) begin
      // falling edge of the active-low button
      if (cur.button_prev && !poll.button_level && (nxt.mode != MODE_UPDATE)) begin
        nxt.mode          = MODE_UPDATE;
        nxt.count         = '0;
        nxt.entry         = '0;
        res.change_prompt = 1'b1;
      end
      nxt.button_prev = poll.button_level;
    end

    res.led_lit      = nxt.led;
    res.current_mode = nxt.mode;
    res.block_active = nxt.active;
  end

endmodule

@@ sv/password_lock_controller.sv @@
// A poll is first registered in the poll stage, then its result in the result stage.
// Throughput: one poll per cycle; both stages hold while the result waits.
// The lock state is updated at the same edge that registers the result,
// so each poll sees everything earlier polls did.
// Reset (rst, synchronous): verify mode, entry empty, password "0000",
// LED off, block active, button released; both stages empty.
module password_lock_controller
  import pwl_pkg::*;
(
  input logic         clk,
  input logic         rst,
  pwl_poll_if.sink    poll,
  pwl_result_if.source result
);

  logic        poll_q_valid;
  poll_t       poll_q;
  logic        res_valid;
  result_t     res_q;
  lock_state_t state;
  lock_state_t state_next;
  result_t     res_next;
  logic        advance;

  assign advance    = !res_valid || result.ready;
  assign poll.ready = !poll_q_valid || advance;

  pwl_step u_step (
    .poll (poll_q),
    .cur  (state),
    .nxt  (state_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_q_valid      <= 1'b0;
      res_valid         <= 1'b0;
      state.mode        <= MODE_VERIFY;
      state.count       <= '0;
      state.entry       <= '0;
      state.stored      <= {PASS_LEN{CH_ZERO}};
      state.button_prev <= 1'b1;
      state.led         <= 1'b0;
      state.active      <= 1'b1;
    end else begin
      if (poll.ready) begin
        poll_q_valid <= poll.valid;
      end
      if (advance) begin
        res_valid <= poll_q_valid;
        if (poll_q_valid) begin
          state <= state_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (poll.ready && poll.valid) begin
      poll_q.char_valid   <= poll.char_valid;
      poll_q.char_code    <= poll.char_code;
      poll_q.button_level <= poll.button_level;
      poll_q.restart      <= poll.restart;
    end
    if (advance && poll_q_valid) begin
      res_q <= res_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.echo_valid    = res_q.echo_valid;
  assign result.echo_code     = res_q.echo_code;
  assign result.entry_event   = res_q.entry_event;
  assign result.change_prompt = res_q.change_prompt;
  assign result.led_lit       = res_q.led_lit;
  assign result.current_mode  = res_q.current_mode;
  assign result.block_active  = res_q.block_active;

endmodule

@@ tb/lock_checker.sv @@
// Passive checker: watches both channels, predicts each lock result and compares it.
`timescale 1ns / 100ps

module lock_checker
  import pwl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  pwl_poll_if          poll,
  pwl_result_if        result,
  output int           fail_count,
  output int           pending,
  output int           checked,
  output int           n_granted,
  output int           n_denied,
  output int           n_updated,
  output int           n_exit,
  output int           n_prompt
);

  // Shadow copy of the lock
  mode_t   lk_mode;
  int      lk_count;
  pass_t   lk_entry;
  pass_t   lk_stored;
  logic    lk_btn_prev;
  logic    lk_led;
  logic    lk_active;

  result_t due_results[$];

  function automatic void drop_entry();
    lk_count = 0;
    lk_entry = '0;
  endfunction

  function automatic result_t predict_poll(input logic cv, input logic [7:0] ch,
                                           input logic lvl, input logic rs);
    result_t r;
    logic    watch_button;
    r = '0;
    watch_button = 1'b1;
    if (rs) begin
      lk_active = 1'b1;
      lk_mode = MODE_VERIFY;
      drop_entry();
      lk_led = 1'b0;
    end
    if (!lk_active) begin
      // button line still tracked so a restart sees no stale edge
      lk_btn_prev = lvl;
      watch_button = 1'b0;
    end else if (cv) begin
      r.echo_valid = 1'b1;
      r.echo_code = ch;
      if (ch == CH_LOWER_E || ch == CH_UPPER_E) begin
        r.entry_event = EV_EXIT;
        lk_active = 1'b0;
        lk_led = 1'b0;
        watch_button = 1'b0;
      end else if (ch == CH_CR || ch == CH_LF) begin
        watch_button = 1'b0;
        if (lk_mode == MODE_SUCCESS) begin
          r.entry_event = EV_ALREADY;
          drop_entry();
        end else if (lk_count != 0) begin
          if (lk_mode == MODE_VERIFY) begin
            if (lk_entry == lk_stored) begin
              r.entry_event = EV_GRANTED;
              lk_led = 1'b1;
              lk_mode = MODE_SUCCESS;
            end else begin
              r.entry_event = EV_DENIED;
            end
          end else if (lk_mode == MODE_UPDATE) begin
            lk_stored = lk_entry;
            r.entry_event = EV_UPDATED;
            lk_led = 1'b0;
            lk_mode = MODE_VERIFY;
          end
          drop_entry();
        end
      end else if ((lk_mode == MODE_VERIFY || lk_mode == MODE_UPDATE) &&
                   ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
        if (lk_count < PASS_LEN) begin
          lk_entry[lk_count] = ch;
          lk_count++;
        end
      end
    end
    if (watch_button) begin
      if (lk_btn_prev && !lvl && lk_mode != MODE_UPDATE) begin
        lk_mode = MODE_UPDATE;
        drop_entry();
        r.change_prompt = 1'b1;
      end
      lk_btn_prev = lvl;
    end
    r.led_lit = lk_led;
    r.current_mode = lk_mode;
    r.block_active = lk_active;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      due_results.delete();
      lk_mode = MODE_VERIFY;
      drop_entry();
      lk_stored = {PASS_LEN{CH_ZERO}};
      lk_btn_prev = 1'b1;
      lk_led = 1'b0;
      lk_active = 1'b1;
    end else begin
      // drain before fill: a result never belongs to a poll of the same edge
      if (result.valid && result.ready) begin
        got.echo_valid    = result.echo_valid;
        got.echo_code     = result.echo_code;
        got.entry_event   = result.entry_event;
        got.change_prompt = result.change_prompt;
        got.led_lit       = result.led_lit;
        got.current_mode  = result.current_mode;
        got.block_active  = result.block_active;
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer with no poll outstanding (event %0d, mode %0d)",
                   $time, got.entry_event, got.current_mode);
        end else begin
          want = due_results.pop_front();
          checked++;
          check_field("echo_valid", 8'(want.echo_valid), 8'(got.echo_valid));
          check_field("echo_code", want.echo_code, got.echo_code);
          check_field("entry_event", 8'(want.entry_event), 8'(got.entry_event));
          check_field("change_prompt", 8'(want.change_prompt), 8'(got.change_prompt));
          check_field("led_lit", 8'(want.led_lit), 8'(got.led_lit));
          check_field("current_mode", 8'(want.current_mode), 8'(got.current_mode));
          check_field("block_active", 8'(want.block_active), 8'(got.block_active));
          case (want.entry_event)
            EV_GRANTED: n_granted++;
            EV_DENIED:  n_denied++;
            EV_UPDATED: n_updated++;
            EV_EXIT:    n_exit++;
            default: ;
          endcase
          if (want.change_prompt) n_prompt++;
        end
      end
      if (poll.valid && poll.ready)
        due_results.push_back(predict_poll(poll.char_valid, poll.char_code,
                                           poll.button_level, poll.restart));
    end
    pending = due_results.size();
  end

endmodule

@@ tb/password_lock_controller_tb.sv @@
// Top of the lock testbench: clock, reset, poll stimulus, result drain and verdict.
`timescale 1ns / 100ps

module password_lock_controller_tb
  import pwl_pkg::*;
();

  localparam int RANDOM_POLLS = 550;

  typedef enum {
    SEQ_GOOD_TRY, SEQ_BAD_TRY, SEQ_CHANGE, SEQ_EXIT, SEQ_NOISE, SEQ_GRANT_MORE, SEQ_BARE_LINE
  } poll_seq_t;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_BLOCKS} drain_style_t;

  logic clk = 1'b0;
  logic rst;

  pwl_poll_if   poll_ch();
  pwl_result_if result_ch();

  int fail_count, pending, checked;
  int n_granted, n_denied, n_updated, n_exit, n_prompt;

  // stimulus-side guesses, used only to steer sequences
  logic       btn_level;
  logic       lock_on;
  logic [7:0] pw_chars [PASS_LEN];
  int         pw_len;
  int         burst_left;
  int         sent_count;
  int         total_polls;

  password_lock_controller dut (
    .clk    (clk),
    .rst    (rst),
    .poll   (poll_ch),
    .result (result_ch)
  );

  lock_checker chk (
    .clk        (clk),
    .rst        (rst),
    .poll       (poll_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .n_granted  (n_granted),
    .n_denied   (n_denied),
    .n_updated  (n_updated),
    .n_exit     (n_exit),
    .n_prompt   (n_prompt)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] printable_char();
    logic [7:0] c;
    do c = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
    while (c == CH_LOWER_E || c == CH_UPPER_E);
    return c;
  endfunction

  function automatic logic [7:0] line_end();
    return ($urandom_range(0, 1) == 1) ? CH_CR : CH_LF;
  endfunction

  // One poll transfer; the sender may idle between bursts of random length.
  task automatic send_poll(input logic cv, input logic [7:0] ch, input logic rs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        poll_ch.valid     <= 1'b0;
        poll_ch.char_code <= 8'($urandom_range(0, 255));
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    @(negedge clk);
    poll_ch.valid        <= 1'b1;
    poll_ch.char_valid   <= cv;
    poll_ch.char_code    <= ch;
    poll_ch.button_level <= btn_level;
    poll_ch.restart      <= rs;
    do @(posedge clk); while (!poll_ch.ready);
    burst_left--;
    total_polls++;
    if (rs) lock_on = 1'b1;
    if (lock_on) sent_count++;
    if (lock_on && cv && (ch == CH_LOWER_E || ch == CH_UPPER_E)) lock_on = 1'b0;
  endtask

  task automatic try_password(input bit right);
    int  n;
    bit  fresh;
    n = right ? pw_len : $urandom_range(1, PASS_LEN + 1);
    fresh = ($urandom_range(0, 1) == 1);
    for (int i = 0; i < n; i++)
      send_poll(1'b1, (right || (i < pw_len && $urandom_range(0, 2) != 0)) ?
                pw_chars[i] : printable_char(), fresh && i == 0);
    send_poll(1'b1, line_end(), 1'b0);
  endtask

  task automatic change_password();
    int         n;
    int         release_at;
    logic [7:0] c;
    if (!btn_level) begin
      btn_level = 1'b1;
      send_poll(1'b0, 8'h00, 1'b0);
    end
    btn_level = 1'b0;
    send_poll(1'b0, 8'h00, 1'b0);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, PASS_LEN + 2) : $urandom_range(1, PASS_LEN);
    release_at = $urandom_range(0, n);
    for (int i = 0; i < n; i++) begin
      if (i == release_at) btn_level = 1'b1;
      c = printable_char();
      if (i < PASS_LEN) pw_chars[i] = c;
      send_poll(1'b1, c, 1'b0);
    end
    send_poll(1'b1, line_end(), 1'b0);
    pw_len = (n < PASS_LEN) ? n : PASS_LEN;
  endtask

  task automatic leave_and_return();
    int idle;
    btn_level = 1'($urandom_range(0, 1));
    send_poll(1'b1, ($urandom_range(0, 1) == 1) ? CH_LOWER_E : CH_UPPER_E, 1'b0);
    idle = $urandom_range(0, 3);
    repeat (idle) begin
      btn_level = 1'($urandom_range(0, 1));
      send_poll(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
    end
    send_poll(1'($urandom_range(0, 1)), printable_char(), 1'b1);
  endtask

  task automatic poll_noise();
    int         k;
    logic [7:0] c;
    k = $urandom_range(1, 6);
    repeat (k) begin
      if ($urandom_range(0, 2) == 0) btn_level = ~btn_level;
      c = ($urandom_range(0, 3) == 0) ? line_end() : 8'($urandom_range(0, 255));
      send_poll(1'($urandom_range(0, 1)), c, $urandom_range(0, 15) == 0);
    end
  endtask

  // result drain: the stall style is picked anew for each span of random length
  initial begin
    drain_style_t style;
    int           span;
    result_ch.ready = 1'b0;
    forever begin
      style = drain_style_t'($urandom_range(0, 3));
      span = $urandom_range(16, 96);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        case (style)
          RDY_ALWAYS: result_ch.ready <= 1'b1;
          RDY_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
          RDY_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
          default:    result_ch.ready <= ((k % 8) >= 5);
        endcase
      end
    end
  end

  initial begin
    poll_seq_t kind;
    rst = 1'b1;
    poll_ch.valid = 1'b0;
    poll_ch.char_valid = 1'b0;
    poll_ch.char_code = 8'h00;
    poll_ch.button_level = 1'b1;
    poll_ch.restart = 1'b0;
    btn_level = 1'b1;
    lock_on = 1'b1;
    burst_left = 0;
    sent_count = 0;
    total_polls = 0;
    for (int i = 0; i < PASS_LEN; i++) pw_chars[i] = CH_ZERO;
    pw_len = PASS_LEN;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: factory code, already granted, update with overflow, junk, deny, exit
    send_poll(1'b0, 8'h00, 1'b0);
    repeat (PASS_LEN) send_poll(1'b1, CH_ZERO, 1'b0);
    send_poll(1'b1, CH_CR, 1'b0);
    send_poll(1'b1, CH_LF, 1'b0);
    send_poll(1'b1, "x", 1'b0);
    btn_level = 1'b0;
    send_poll(1'b0, 8'h00, 1'b0);
    send_poll(1'b1, CH_PRINT_LO, 1'b0);
    send_poll(1'b1, CH_PRINT_HI, 1'b0);
    send_poll(1'b1, "A", 1'b0);
    send_poll(1'b1, "B", 1'b0);
    send_poll(1'b1, "C", 1'b0);   // entry full, dropped
    btn_level = 1'b1;
    send_poll(1'b1, CH_LF, 1'b0); // release not acted on with a line end
    pw_chars[0] = CH_PRINT_LO;
    pw_chars[1] = CH_PRINT_HI;
    pw_chars[2] = "A";
    pw_chars[3] = "B";
    send_poll(1'b1, 8'hFF, 1'b0);
    send_poll(1'b1, 8'h1F, 1'b0);
    send_poll(1'b1, 8'h7F, 1'b0);
    send_poll(1'b1, CH_CR, 1'b0);
    send_poll(1'b1, "1", 1'b0);
    send_poll(1'b1, CH_CR, 1'b0);
    btn_level = 1'b0;
    send_poll(1'b1, CH_LOWER_E, 1'b0);
    send_poll(1'b1, "A", 1'b0);
    btn_level = 1'b1;
    send_poll(1'b1, CH_UPPER_E, 1'b1); // restart, then exit again

    sent_count = 0;
    while (sent_count < RANDOM_POLLS) begin
      if (!lock_on) send_poll(1'b0, 8'h00, 1'b1);
      kind = poll_seq_t'($urandom_range(SEQ_GOOD_TRY, SEQ_BARE_LINE));
      case (kind)
        SEQ_GOOD_TRY: try_password(1'b1);
        SEQ_BAD_TRY:  try_password(1'b0);
        SEQ_CHANGE:   change_password();
        SEQ_EXIT:     leave_and_return();
        SEQ_NOISE:    poll_noise();
        SEQ_GRANT_MORE: begin
          try_password(1'b1);
          send_poll(1'b1, line_end(), 1'b0);
          send_poll(1'b1, printable_char(), 1'b0);
        end
        default: send_poll(1'b1, line_end(), 1'b0);
      endcase
    end

    @(negedge clk);
    poll_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Checked %0d results of %0d polls: %0d granted, %0d denied, %0d updates,",
             checked, total_polls, n_granted, n_denied, n_updated);
    $display("%0d exits, %0d change prompts, under random sender gaps and drain stalls.",
             n_exit, n_prompt);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
